FILE: hw/rtl/plc_pkg.sv
package plc_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int COORD_W          = 16;
   localparam int CNT_W            = 7;
   localparam int IDX_W            = 7;
   localparam int LEN_W            = 34;
   localparam int T_W              = 17;
   localparam int FRAC_W           = 17;
   localparam int STEP_W           = 6;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                       kind;
      logic [IDX_W-1:0]           index;
      logic signed [COORD_W-1:0]  z;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  x;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

endpackage

FILE: hw/rtl/plc_ram.sv
module plc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

FILE: hw/rtl/plc_front.sv
module plc_front #(
   parameter int MAX_SEGMENTS = plc_pkg::MAX_SEGMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  plc_pkg::item_type  req_item,
   output plc_pkg::queue_type q_out,
   input  logic               q_pop
);
   import plc_pkg::*;

   item_type   ent_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, drop;

   assign req_tready = (cnt_ff != 2'd2);
   assign drop  = (req_item.kind == REQ_LOAD) && (32'(req_item.index) > MAX_SEGMENTS);
   assign push  = req_tvalid && req_tready && !drop;
   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.item  = ent_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = q_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= req_item;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: hw/rtl/plc_div.sv
module plc_div #(
   parameter int DV_W = 42
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DV_W:0]              rem_init,
   input  logic [plc_pkg::LEN_W-1:0]  low_init,
   input  logic [DV_W-1:0]            divisor,
   input  logic [plc_pkg::STEP_W-1:0] steps,
   output logic                       done,
   output logic [plc_pkg::LEN_W-1:0]  quotient
);
   import plc_pkg::*;

   logic [DV_W:0]     rem_ff, rem_in, r2;
   logic [LEN_W-1:0]  low_ff, low_in, q_ff, q_in;
   logic [DV_W-1:0]   div_ff;
   logic [STEP_W-1:0] cnt_ff, cnt_in, steps_ff;
   logic              busy_ff, busy_in, done_ff, done_in, ge;

   assign r2 = {rem_ff[DV_W-1:0], low_ff[LEN_W-1]};
   assign ge = (r2 >= {1'b0, div_ff});
   assign done = done_ff;
   assign quotient = q_ff;

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem_init;
         low_in  = low_init;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? (r2 - {1'b0, div_ff}) : r2;
         low_in = {low_ff[LEN_W-2:0], 1'b0};
         q_in   = {q_ff[LEN_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == steps_ff - 1'b1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (start) begin
         div_ff   <= divisor;
         steps_ff <= steps;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

FILE: hw/rtl/plc_back.sv
module plc_back #(
   parameter int MAX_SEGMENTS = plc_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  plc_pkg::queue_type        q_in,
   output logic                      q_pop,
   input  logic [plc_pkg::CNT_W-1:0] seg_count,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [plc_pkg::T_W-1:0]   rsp_t,
   output logic                      rsp_found,
   output logic [plc_pkg::LEN_W-1:0] rsp_dist
);
   import plc_pkg::*;

   localparam int IW   = $clog2(MAX_SEGMENTS + 1);
   localparam int DW   = LEN_W + IW;
   localparam int DV_W = DW + 1;
   localparam int VW   = 3 * COORD_W;
   localparam int DEP  = MAX_SEGMENTS + 1;

   localparam logic [3:0] B_IDLE = 4'd0;
   localparam logic [3:0] B_RD   = 4'd1;
   localparam logic [3:0] B_DIFF = 4'd2;
   localparam logic [3:0] B_MUL  = 4'd3;
   localparam logic [3:0] B_SUM  = 4'd4;
   localparam logic [3:0] B_CLS  = 4'd5;
   localparam logic [3:0] B_SQ1  = 4'd6;
   localparam logic [3:0] B_SQ2  = 4'd7;
   localparam logic [3:0] B_DIV  = 4'd8;
   localparam logic [3:0] B_CMP  = 4'd9;
   localparam logic [3:0] B_TM   = 4'd10;
   localparam logic [3:0] B_TX   = 4'd11;
   localparam logic [3:0] B_TDIV = 4'd12;
   localparam logic [3:0] B_OUT  = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic [IW-1:0] i_ff, n_ff, best_i_ff;
   logic signed [COORD_W-1:0] p_ff [3];
   logic [VW-1:0] u_data, v_data;
   logic signed [COORD_W:0] dk_ff [3], wk_ff [3], ek_ff [3];
   logic signed [2*COORD_W+1:0] pdd_ff [3], pwd_ff [3], pww_ff [3], pee_ff [3];
   logic [LEN_W-1:0] len_ff, ww_ff, ee_ff, c_ff, d_ff, best_ff, best_len_ff, best_c_ff;
   logic signed [LEN_W:0] dot_ff;
   logic [LEN_W-1:0] phh_ff, phl_ff, pll_ff;
   logic [2*LEN_W-1:0] sq;
   logic [DW-1:0] num_ff, den_ff;
   logic [DW+FRAC_W:0] xval;
   logic skip_ff, found_ff;
   logic rv_ff, rf_ff;
   logic [T_W-1:0] rt_ff, t_ff;
   logic [LEN_W-1:0] rd_ff;
   logic ram_we;
   logic div_start, div_done;
   logic [DV_W:0] div_rem;
   logic [LEN_W-1:0] div_low, div_q;
   logic [DV_W-1:0] div_dvs;
   logic [STEP_W-1:0] div_steps;
   logic out_free;
   logic [IW-1:0] n_sat;

   assign out_free  = !rv_ff || rsp_ready;
   assign rsp_valid = rv_ff;
   assign rsp_t     = rt_ff;
   assign rsp_found = rf_ff;
   assign rsp_dist  = rd_ff;
   assign q_pop  = (state_ff == B_IDLE) && q_in.valid;
   assign ram_we = q_pop && (q_in.item.kind == REQ_LOAD);
   assign n_sat  = (32'(seg_count) > MAX_SEGMENTS) ? IW'(MAX_SEGMENTS) : IW'(seg_count);

   plc_ram #(.WIDTH(VW), .DEPTH(DEP)) u_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (IW'(q_in.item.index)),
      .wr_data   ({q_in.item.z, q_in.item.y, q_in.item.x}),
      .rd_addr_a (i_ff),
      .rd_addr_b (i_ff + 1'b1),
      .rd_data_a (u_data),
      .rd_data_b (v_data)
   );

   assign sq   = {phh_ff, {LEN_W{1'b0}}} + {{(LEN_W-FRAC_W-1){1'b0}}, phl_ff, {(FRAC_W+1){1'b0}}}
               + {{LEN_W{1'b0}}, pll_ff};
   assign xval = {1'b0, num_ff, {FRAC_W{1'b0}}} + {{(FRAC_W+1){1'b0}}, den_ff};

   always_comb begin
      div_start = 1'b0;
      div_rem   = '0;
      div_low   = '0;
      div_dvs   = '0;
      div_steps = '0;
      case (state_ff)
         B_SQ2: begin
            div_start = 1'b1;
            div_rem   = (DV_W+1)'(sq[2*LEN_W-1:LEN_W]);
            div_low   = sq[LEN_W-1:0];
            div_dvs   = DV_W'(len_ff);
            div_steps = STEP_W'(LEN_W);
         end
         B_TX: begin
            div_start = 1'b1;
            div_rem   = {1'b0, xval[DW+FRAC_W:FRAC_W]};
            div_low   = {xval[FRAC_W-1:0], {(LEN_W-FRAC_W){1'b0}}};
            div_dvs   = {den_ff, 1'b0};
            div_steps = STEP_W'(FRAC_W);
         end
         default: begin
         end
      endcase
   end

   plc_div #(.DV_W(DV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .low_init (div_low),
      .divisor  (div_dvs),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_in.valid && q_in.item.kind == REQ_QUERY) begin
               state_in = (n_sat == '0) ? B_TM : B_RD;
            end
         end
         B_RD:   state_in = B_DIFF;
         B_DIFF: state_in = B_MUL;
         B_MUL:  state_in = B_SUM;
         B_SUM:  state_in = B_CLS;
         B_CLS: begin
            if (len_ff != '0 && dot_ff > 0 && dot_ff < $signed({1'b0, len_ff})) begin
               state_in = B_SQ1;
            end else begin
               state_in = B_CMP;
            end
         end
         B_SQ1:  state_in = B_SQ2;
         B_SQ2:  state_in = B_DIV;
         B_DIV:  state_in = div_done ? B_CMP : B_DIV;
         B_CMP:  state_in = (i_ff + 1'b1 == n_ff) ? B_TM : B_RD;
         B_TM:   state_in = found_ff ? B_TX : B_OUT;
         B_TX:   state_in = B_TDIV;
         B_TDIV: state_in = div_done ? B_OUT : B_TDIV;
         B_OUT:  state_in = out_free ? B_IDLE : B_OUT;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            p_ff[0] <= q_in.item.x;
            p_ff[1] <= q_in.item.y;
            p_ff[2] <= q_in.item.z;
            n_ff    <= n_sat;
            i_ff    <= '0;
         end
         B_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               dk_ff[k] <= (COORD_W+1)'($signed(v_data[k*COORD_W +: COORD_W]))
                         - (COORD_W+1)'($signed(u_data[k*COORD_W +: COORD_W]));
               wk_ff[k] <= (COORD_W+1)'(p_ff[k])
                         - (COORD_W+1)'($signed(u_data[k*COORD_W +: COORD_W]));
               ek_ff[k] <= (COORD_W+1)'(p_ff[k])
                         - (COORD_W+1)'($signed(v_data[k*COORD_W +: COORD_W]));
            end
         end
         B_MUL: begin
            for (int k = 0; k < 3; k++) begin
               pdd_ff[k] <= dk_ff[k] * dk_ff[k];
               pwd_ff[k] <= wk_ff[k] * dk_ff[k];
               pww_ff[k] <= wk_ff[k] * wk_ff[k];
               pee_ff[k] <= ek_ff[k] * ek_ff[k];
            end
         end
         B_SUM: begin
            len_ff <= LEN_W'(pdd_ff[0]) + LEN_W'(pdd_ff[1]) + LEN_W'(pdd_ff[2]);
            ww_ff  <= LEN_W'(pww_ff[0]) + LEN_W'(pww_ff[1]) + LEN_W'(pww_ff[2]);
            ee_ff  <= LEN_W'(pee_ff[0]) + LEN_W'(pee_ff[1]) + LEN_W'(pee_ff[2]);
            dot_ff <= (LEN_W+1)'(pwd_ff[0]) + (LEN_W+1)'(pwd_ff[1])
                    + (LEN_W+1)'(pwd_ff[2]);
         end
         B_CLS: begin
            skip_ff <= (len_ff == '0);
            if (dot_ff <= 0) begin
               c_ff <= '0;
               d_ff <= ww_ff;
            end else if (dot_ff >= $signed({1'b0, len_ff})) begin
               c_ff <= len_ff;
               d_ff <= ee_ff;
            end else begin
               c_ff <= dot_ff[LEN_W-1:0];
            end
         end
         B_SQ1: begin
            phh_ff <= c_ff[LEN_W-1:FRAC_W] * c_ff[LEN_W-1:FRAC_W];
            phl_ff <= c_ff[LEN_W-1:FRAC_W] * c_ff[FRAC_W-1:0];
            pll_ff <= c_ff[FRAC_W-1:0] * c_ff[FRAC_W-1:0];
         end
         B_DIV: begin
            if (div_done) begin
               d_ff <= ww_ff - div_q;
            end
         end
         B_CMP: begin
            i_ff <= i_ff + 1'b1;
            if (!skip_ff && (!found_ff || d_ff < best_ff)) begin
               best_ff     <= d_ff;
               best_i_ff   <= i_ff;
               best_len_ff <= len_ff;
               best_c_ff   <= c_ff;
            end
         end
         B_TM: begin
            num_ff <= DW'(best_i_ff) * DW'(best_len_ff) + DW'(best_c_ff);
            den_ff <= DW'(n_ff) * DW'(best_len_ff);
         end
         B_TDIV: begin
            if (div_done) begin
               t_ff <= div_q[T_W-1:0];
            end
         end
         default: begin
         end
      endcase
      if (state_ff == B_OUT && out_free) begin
         rt_ff <= found_ff ? t_ff : '0;
         rd_ff <= found_ff ? best_ff : '0;
         rf_ff <= found_ff;
      end
      if (reset) begin
         state_ff <= B_IDLE;
         found_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_IDLE) begin
            found_ff <= 1'b0;
         end else if (state_ff == B_CMP && !skip_ff) begin
            found_ff <= 1'b1;
         end
         if (state_ff == B_OUT && out_free) begin
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: hw/rtl/polyline_closest_param.sv
// Closest parameter on a 3D polyline of equal segments over t in [0,1].
// req: tuser = req_type (0 load vertex, 1 query); tdata = vertex_index, x, y, z.
// A load writes one vertex slot and gives no word on rsp; a load whose index is
// above MAX_SEGMENTS is dropped. A query gives one rsp word: t_param (1.16),
// best_dist_sq, and found in tuser.
// csr: writes segment_count; write only while the block is idle.
// Words from req enter a two-deep queue; a sequencer behind it executes them in
// order, so req keeps taking words while a query runs or rsp is stalled.
// Steps: a load is written to its vertex slot as it leaves the queue. A query
// reads each segment's two vertices, then forms differences, products, sums and
// the clamp; an interior segment also runs the bit-serial divider on the projection
// term. The same divider then gives t_param (skipped when no segment qualifies).
// rsp holds its word until rsp_tready; the sequencer then waits, and req stops
// once the queue is full.
// Reset clears the queue, the sequencer and rsp_tvalid and sets segment_count
// to 1. Vertex storage is not cleared; load every vertex before querying.
module polyline_closest_param #(
   parameter int MAX_SEGMENTS = plc_pkg::MAX_SEGMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // vertex_index[6:0], x[22:7], y[38:23], z[54:39]
   input  logic [0:0]  req_tuser,   // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // t_param[16:0], best_dist_sq[50:17]
   output logic [0:0]  rsp_tuser,   // found[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);
   import plc_pkg::*;

   logic [CNT_W-1:0] seg_ff;
   item_type         req_item;
   queue_type        q_data;
   logic             q_pop;
   logic [T_W-1:0]   rsp_t;
   logic [LEN_W-1:0] rsp_dist;
   logic             rsp_found;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= CNT_W'(1);
      end else if (csr_valid) begin
         seg_ff <= csr_data;
      end
   end

   assign req_item.kind  = req_tuser[0];
   assign req_item.index = req_tdata[6:0];
   assign req_item.x     = req_tdata[22:7];
   assign req_item.y     = req_tdata[38:23];
   assign req_item.z     = req_tdata[54:39];

   plc_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .q_out      (q_data),
      .q_pop      (q_pop)
   );

   plc_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q_data),
      .q_pop     (q_pop),
      .seg_count (seg_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_t     (rsp_t),
      .rsp_found (rsp_found),
      .rsp_dist  (rsp_dist)
   );

   assign rsp_tdata = {5'b0, rsp_dist, rsp_t};
   assign rsp_tuser = rsp_found;

endmodule

FILE: dv/polyline_closest_check.sv
module polyline_closest_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [6:0]  csr_data,
   output int          errors,
   output int          pending
);
   import plc_pkg::*;

   typedef struct packed {
      logic [T_W-1:0]   t_param;
      logic             found;
      logic [LEN_W-1:0] dist_sq;
   } closest_type;

   logic signed [COORD_W-1:0] vert_x [0:MAX_SEGMENTS_DEF];
   logic signed [COORD_W-1:0] vert_y [0:MAX_SEGMENTS_DEF];
   logic signed [COORD_W-1:0] vert_z [0:MAX_SEGMENTS_DEF];
   logic [CNT_W-1:0]          seg_count;
   closest_type               want_q [$];

   function automatic longint point_dist(longint ax, longint ay, longint az,
                                         longint bx, longint by, longint bz);
      return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) + (az - bz) * (az - bz);
   endfunction

   function automatic closest_type closest_on_polyline(longint px, longint py, longint pz);
      closest_type    res;
      longint         n, ux, uy, uz, wx, wy, wz, dx, dy, dz, len2, dot, c, d, best;
      logic [127:0]   wide, num, den;
      logic [T_W-1:0] t_best;
      bit             hit;
      res = '0;
      hit = 0;
      best = 0;
      t_best = '0;
      n = (seg_count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : seg_count;
      for (longint i = 0; i < n; i++) begin
         ux = vert_x[i]; uy = vert_y[i]; uz = vert_z[i];
         wx = vert_x[i+1]; wy = vert_y[i+1]; wz = vert_z[i+1];
         dx = wx - ux; dy = wy - uy; dz = wz - uz;
         len2 = dx * dx + dy * dy + dz * dz;
         dot = (px - ux) * dx + (py - uy) * dy + (pz - uz) * dz;
         if (len2 == 0) continue;
         if (dot <= 0) begin
            c = 0;
            d = point_dist(px, py, pz, ux, uy, uz);
         end else if (dot >= len2) begin
            c = len2;
            d = point_dist(px, py, pz, wx, wy, wz);
         end else begin
            c = dot;
            wide = 128'(c) * 128'(c);
            wide = wide / 128'(len2);
            d = point_dist(px, py, pz, ux, uy, uz) - longint'(wide);
         end
         num = 128'(i) * 128'(len2) + 128'(c);
         den = 128'(n) * 128'(len2);
         wide = (num * 128'd131072 + den) / (128'd2 * den);
         if (!hit || d < best) begin
            hit = 1;
            best = d;
            t_best = wide[T_W-1:0];
         end
      end
      if (hit) begin
         res.found = 1'b1;
         res.t_param = t_best;
         res.dist_sq = best[LEN_W-1:0];
      end
      return res;
   endfunction

   assign pending = want_q.size();

   always @(posedge clock) begin
      closest_type want;
      int          bad;
      bad = 0;
      if (reset) begin
         want_q.delete();
         seg_count <= 7'd1;
         errors <= 0;
      end else begin
         if (csr_valid && csr_ready) seg_count <= csr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == REQ_LOAD) begin
               if (req_tdata[6:0] <= MAX_SEGMENTS_DEF) begin
                  vert_x[req_tdata[6:0]] <= req_tdata[22:7];
                  vert_y[req_tdata[6:0]] <= req_tdata[38:23];
                  vert_z[req_tdata[6:0]] <= req_tdata[54:39];
               end
            end else begin
               want_q = {want_q, closest_on_polyline(
                  longint'($signed(req_tdata[22:7])),
                  longint'($signed(req_tdata[38:23])),
                  longint'($signed(req_tdata[54:39])))};
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (want_q.size() == 0) begin
               $error("rsp word with no query outstanding");
               bad = bad + 1;
            end else begin
               want = want_q.pop_front();
               if (rsp_tdata[16:0] !== want.t_param) begin
                  $error("t_param expected %0d actual %0d", want.t_param, rsp_tdata[16:0]);
                  bad = bad + 1;
               end
               if (rsp_tuser[0] !== want.found) begin
                  $error("found expected %0d actual %0d", want.found, rsp_tuser[0]);
                  bad = bad + 1;
               end
               if (rsp_tdata[50:17] !== want.dist_sq) begin
                  $error("best_dist_sq expected %0d actual %0d", want.dist_sq,
                         rsp_tdata[50:17]);
                  bad = bad + 1;
               end
            end
         end
         errors <= errors + bad;
      end
   end

endmodule

FILE: dv/tb_polyline_closest_param.sv
module tb_polyline_closest_param;
   import plc_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;
   int          errors;
   int          pending;
   int          cycles = 0;
   bit          calm = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   polyline_closest_param DUT (.*);

   polyline_closest_check u_check (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always begin
      int stall;
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!rsp_tvalid);
   end

   function automatic logic [15:0] pick_coord();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return 16'h8000;
         1: return 16'h7fff;
         2, 3, 4: return 16'($urandom_range(0, 2)) - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_word(logic kind, logic [6:0] idx,
                            logic [15:0] x, logic [15:0] y, logic [15:0] z);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {1'b0, z, y, x, idx};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic set_segments(logic [6:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (64) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   int          counts [13] = '{3, 1, 2, 64, 0, 5, 127, 8, 4, 65, 2, 6, 1};
   int          r;
   logic [6:0]  idx;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // fill every vertex slot before any query
      for (int k = 0; k <= MAX_SEGMENTS_DEF; k++)
         send_word(REQ_LOAD, 7'(k), pick_coord(), pick_coord(), pick_coord());
      send_word(REQ_LOAD, 7'd0, 16'h8000, 16'h8000, 16'h8000);
      send_word(REQ_LOAD, 7'd1, 16'h7fff, 16'h7fff, 16'h7fff);
      send_word(REQ_QUERY, 7'd0, 16'h8000, 16'h8000, 16'h8000);
      send_word(REQ_QUERY, 7'd0, 16'h7fff, 16'h7fff, 16'h7fff);
      send_word(REQ_QUERY, 7'd0, 16'h7fff, 16'h8000, 16'h0000);
      send_word(REQ_QUERY, 7'd127, 16'h0000, 16'h0000, 16'h0000);
      send_word(REQ_LOAD, 7'd65, 16'h1234, 16'h1234, 16'h1234);
      send_word(REQ_LOAD, 7'd127, 16'hffff, 16'hffff, 16'hffff);
      send_word(REQ_QUERY, 7'd0, 16'h0001, 16'hffff, 16'h0000);
      // degenerate polyline: every segment has zero length
      send_word(REQ_LOAD, 7'd1, 16'h8000, 16'h8000, 16'h8000);
      send_word(REQ_QUERY, 7'd0, 16'h0000, 16'h0000, 16'h0000);
      set_segments(7'd2);
      send_word(REQ_LOAD, 7'd2, 16'h0100, 16'h0000, 16'h0000);
      send_word(REQ_QUERY, 7'd0, 16'h0000, 16'h0000, 16'h0000);
      set_segments(7'd0);
      send_word(REQ_QUERY, 7'd0, 16'h0005, 16'h0005, 16'h0005);
      set_segments(7'd127);
      send_word(REQ_QUERY, 7'd0, 16'h0000, 16'h0000, 16'h0000);

      for (int ph = 0; ph < 13; ph++) begin
         calm = 0;
         set_segments(7'(counts[ph]));
         calm = (ph % 4 == 3);
         for (int k = 0; k < 100; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               idx = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
                                                 : 7'($urandom_range(0, 64));
               send_word(REQ_LOAD, idx, pick_coord(), pick_coord(), pick_coord());
            end else begin
               send_word(REQ_QUERY, 7'($urandom), pick_coord(), pick_coord(),
                         pick_coord());
            end
         end
      end
      calm = 0;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
